// ----- src/wptd_pkg.sv -----
// Package for the waypoint turn-then-drive controller.
// Holds sizes, fixed-point constants, the CORDIC arctangent table and shared types.
package wptd_pkg;

	localparam int MaxWaypoints = 16;
	localparam int SlotW        = 4;
	localparam int CordicIters  = 16;
	localparam int IterW        = 5;

	// CORDIC datapath width: Q8.8 difference (17 bits) scaled by 2^14, plus growth.
	localparam int CW = 36;
	localparam int ZW = 28;

	localparam logic signed [ZW-1:0] PiQ24   = 28'sd52707179;
	localparam logic signed [15:0]   PiQ12   = 16'sd12868;
	localparam logic signed [17:0]   TwoPiQ12 = 18'sd25736;
	localparam logic [23:0]          InvKQ24 = 24'd10188014;

	typedef enum logic [1:0] {
		PH_ROTATE  = 2'd0,
		PH_DRIVE   = 2'd1,
		PH_REACHED = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ITER,
		ST_DIST,
		ST_DECIDE,
		ST_OUT
	} state_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load_start;  // capture dx, dy and pose
		logic iter_en;     // run one CORDIC iteration
		logic dist_en;     // form distance and error terms
		logic decide_en;   // form products and decisions
	} dp_cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic       iter_done;
		logic       head_ok;
		logic       pos_ok;
	} dp_sts_t;

	function automatic logic [ZW-1:0] atan_q24(input logic [IterW-1:0] i);
		logic [ZW-1:0] r;
		begin
			case (i)
				5'd0: r = 28'd13176795;
				5'd1: r = 28'd7778716;
				5'd2: r = 28'd4110060;
				5'd3: r = 28'd2086331;
				5'd4: r = 28'd1047214;
				5'd5: r = 28'd524117;
				5'd6: r = 28'd262123;
				5'd7: r = 28'd131069;
				default: r = 28'd65536 >> (i - 5'd8);
			endcase
			return r;
		end
	endfunction

endpackage

// ----- src/waypoint_turn_then_drive_controller_top.sv -----
// Waypoint turn-then-drive controller, top level.
// A control-step word runs 16 CORDIC iterations on one shared unit, then a distance state
// and a decision state, before its result is raised; load and advance words raise theirs
// the cycle after they are taken. One word at a time: the next word can be taken the
// cycle after the result is taken.
// Reset is asynchronous, active low: configuration registers, controller state, square waypoint table, rotate phase.
module waypoint_turn_then_drive_controller_top import wptd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] pose_heading,
	input  logic [3:0]         load_slot,
	input  logic signed [15:0] load_x,
	input  logic signed [15:0] load_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] turn_rate,
	output logic signed [15:0] forward_speed,
	output logic [1:0]         phase,
	output logic [3:0]         goal_slot,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam logic [2:0] RegHeadGain = 3'd0;
	localparam logic [2:0] RegDistGain = 3'd1;
	localparam logic [2:0] RegMaxTurn  = 3'd2;
	localparam logic [2:0] RegMaxSpeed = 3'd3;
	localparam logic [2:0] RegThresh   = 3'd4;
	localparam logic [2:0] RegCount    = 3'd5;

	logic [15:0] hgain_q, dgain_q;
	logic [14:0] mturn_q, mspeed_q;
	logic [10:0] thr_q;
	logic [4:0]  cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hgain_q  <= 16'd5120;
			dgain_q  <= 16'd2560;
			mturn_q  <= 15'd2048;
			mspeed_q <= 15'd128;
			thr_q    <= 11'd13;
			cnt_q    <= 5'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegHeadGain: hgain_q  <= cfg_data;
				RegDistGain: dgain_q  <= cfg_data;
				RegMaxTurn:  mturn_q  <= cfg_data[14:0];
				RegMaxSpeed: mspeed_q <= cfg_data[14:0];
				RegThresh:   thr_q    <= cfg_data[10:0];
				RegCount:    cnt_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic             tbl_wr, tsel, ssel;
	logic [SlotW-1:0] goal;
	phase_t           ph;
	logic signed [15:0] tcmd, scmd;

	wptd_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_take        (in_valid && !in_stall),
		.func           (func),
		.waypoint_count (cnt_q),
		.out_stall      (out_stall),
		.in_stall       (in_stall),
		.out_valid      (out_valid),
		.cmd            (cmd),
		.sts            (sts),
		.tbl_wr         (tbl_wr),
		.goal           (goal),
		.phase          (ph),
		.turn_sel       (tsel),
		.speed_sel      (ssel)
	);

	wptd_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.wr_en             (tbl_wr),
		.wr_slot           (load_slot),
		.wr_x              (load_x),
		.wr_y              (load_y),
		.goal              (goal),
		.pose_x            (pose_x),
		.pose_y            (pose_y),
		.pose_heading      (pose_heading),
		.heading_gain      (hgain_q),
		.distance_gain     (dgain_q),
		.max_turn_rate     (mturn_q),
		.max_forward_speed (mspeed_q),
		.arrive_threshold  (thr_q),
		.turn_cmd          (tcmd),
		.speed_cmd         (scmd)
	);

	assign turn_rate     = tsel ? tcmd : '0;
	assign forward_speed = ssel ? scmd : '0;
	assign phase         = ph;
	assign goal_slot     = goal;

`ifndef SYNTHESIS
	// A command goes out on at most one of the two channels.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(turn_rate != 0 && forward_speed != 0))
		else $error("turn and speed both commanded");

	// Only the rotate phase carries a turn command.
	a_turn_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && turn_rate != 0) |-> phase == 2'd0)
		else $error("turn command outside rotate phase");

	// Input is never taken while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
`endif

endmodule

// ----- src/wptd_datapath.sv -----
// Datapath of the waypoint controller: waypoint table, CORDIC vectoring unit,
// error terms and saturated proportional commands. Uses wptd_pkg.
module wptd_datapath import wptd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  logic                     wr_en,
	input  logic [SlotW-1:0]         wr_slot,
	input  logic signed [15:0]       wr_x,
	input  logic signed [15:0]       wr_y,
	input  logic [SlotW-1:0]         goal,
	input  logic signed [15:0]       pose_x,
	input  logic signed [15:0]       pose_y,
	input  logic signed [15:0]       pose_heading,
	input  logic [15:0]              heading_gain,
	input  logic [15:0]              distance_gain,
	input  logic [14:0]              max_turn_rate,
	input  logic [14:0]              max_forward_speed,
	input  logic [10:0]              arrive_threshold,
	output logic signed [15:0]       turn_cmd,
	output logic signed [15:0]       speed_cmd
);

	// The table resets to a square, so every entry is a register.
	logic signed [15:0] wx_q [MaxWaypoints];
	logic signed [15:0] wy_q [MaxWaypoints];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxWaypoints; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
			end
			wx_q[0] <= 16'sd768;  wy_q[0] <= 16'sd512;
			wx_q[1] <= 16'sd1792; wy_q[1] <= 16'sd512;
			wx_q[2] <= 16'sd1792; wy_q[2] <= 16'sd1792;
			wx_q[3] <= 16'sd768;  wy_q[3] <= 16'sd1792;
		end else if (wr_en) begin
			wx_q[wr_slot] <= wr_x;
			wy_q[wr_slot] <= wr_y;
		end
	end

	logic signed [16:0] dx_c, dy_c;
	assign dx_c = 17'(wx_q[goal]) - 17'(pose_x);
	assign dy_c = 17'(wy_q[goal]) - 17'(pose_y);

	logic signed [16:0]   dx_q, dy_q;
	logic signed [15:0]   ph_q;
	logic                 zero_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IterW-1:0]     it_q;

	logic signed [CW-1:0] xs0, ys0;
	assign xs0 = CW'(dx_c) <<< 14;
	assign ys0 = CW'(dy_c) <<< 14;

	logic signed [CW-1:0] xsh, ysh;
	assign xsh = x_q >>> it_q;
	assign ysh = y_q >>> it_q;

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			dx_q   <= dx_c;
			dy_q   <= dy_c;
			ph_q   <= pose_heading;
			zero_q <= (dx_c == '0) && (dy_c == '0);
			it_q   <= '0;
			if (dx_c < 0) begin
				x_q <= -xs0;
				y_q <= -ys0;
				z_q <= (dy_c >= 0) ? PiQ24 : -PiQ24;
			end else begin
				x_q <= xs0;
				y_q <= ys0;
				z_q <= '0;
			end
		end else if (cmd.iter_en) begin
			it_q <= it_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				z_q <= z_q + $signed(atan_q24(it_q));
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				z_q <= z_q - $signed(atan_q24(it_q));
			end
		end
	end

	assign sts.iter_done = (it_q == IterW'(CordicIters - 1));

	// Distance, bearing and heading error.
	logic signed [16:0] bearing_c;
	logic signed [ZW-1:0] zr;
	assign zr = z_q + ZW'(2048);
	assign bearing_c = zero_q ? '0 : 17'(zr >>> 12);

	logic [59:0] xk_c;
	assign xk_c = 60'(x_q[CW-2:0]) * 60'(InvKQ24);

	logic [21:0]        dist_s1;
	logic signed [17:0] err_s1;
	logic               pos_ok_s1, head_ok_s1;
	logic signed [17:0] aerr, thr8;
	logic signed [16:0] adx, ady;
	assign aerr = (bearing_c - 17'(ph_q) < 0) ? -(18'(bearing_c) - 18'(ph_q))
	                                         :  (18'(bearing_c) - 18'(ph_q));
	assign adx  = dx_q < 0 ? -dx_q : dx_q;
	assign ady  = dy_q < 0 ? -dy_q : dy_q;
	assign thr8 = 18'({arrive_threshold, 3'b000});

	always_ff @(posedge clk) begin
		if (cmd.dist_en) begin
			dist_s1    <= zero_q ? '0 : 22'((xk_c + (60'd1 << 37)) >> 38);
			err_s1     <= 18'(bearing_c) - 18'(ph_q);
			pos_ok_s1  <= (adx <= $signed(17'(arrive_threshold)))
			           && (ady <= $signed(17'(arrive_threshold)));
			head_ok_s1 <= aerr <= thr8;
		end
	end
	assign sts.head_ok = head_ok_s1;
	assign sts.pos_ok  = pos_ok_s1;

	// Wrap and products.
	logic signed [17:0] h_c;
	always_comb begin
		h_c = err_s1;
		if (h_c > 18'(PiQ12))  h_c = h_c - TwoPiQ12;
		if (h_c < -18'(PiQ12)) h_c = h_c + TwoPiQ12;
	end

	logic signed [34:0] tprod;
	logic signed [34:0] tlim;
	logic [37:0]        vprod;
	logic [29:0]        v;
	assign tprod = $signed({1'b0, heading_gain}) * 35'(h_c);
	assign tlim  = $signed(35'({max_turn_rate, 8'd0}));
	assign vprod = 38'(distance_gain) * 38'(dist_s1);
	assign v     = vprod[37:8];

	always_ff @(posedge clk) begin
		if (cmd.decide_en) begin
			if (tprod > tlim)
				turn_cmd <= 16'(max_turn_rate);
			else if (tprod < -tlim)
				turn_cmd <= -16'(max_turn_rate);
			else
				turn_cmd <= 16'(tprod >>> 8);
			speed_cmd <= (v > 30'(max_forward_speed)) ? 16'(max_forward_speed) : 16'(v);
		end
	end

endmodule

// ----- src/wptd_ctrl.sv -----
// Controller state machine of the waypoint controller: handshake, phase,
// goal pointer and sequencing of the datapath. Uses wptd_pkg.
module wptd_ctrl import wptd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_take,
	input  logic             func,
	input  logic [4:0]       waypoint_count,
	input  logic             out_stall,
	output logic             in_stall,
	output logic             out_valid,
	output dp_cmd_t          cmd,
	input  dp_sts_t          sts,
	output logic             tbl_wr,
	output logic [SlotW-1:0] goal,
	output phase_t           phase,
	output logic             turn_sel,
	output logic             speed_sel
);

	state_t state_q, state_d;
	logic   drive_q, drive_d, reached_q, reached_d;
	logic [SlotW-1:0] goal_q, goal_d;
	logic   tsel_q, tsel_d, ssel_q, ssel_d;
	logic [4:0] n;

	assign n = (waypoint_count == '0) ? 5'd1
	         : (waypoint_count > 5'(MaxWaypoints)) ? 5'(MaxWaypoints) : waypoint_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			drive_q   <= 1'b0;
			reached_q <= 1'b0;
			goal_q    <= '0;
			tsel_q    <= 1'b0;
			ssel_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			drive_q   <= drive_d;
			reached_q <= reached_d;
			goal_q    <= goal_d;
			tsel_q    <= tsel_d;
			ssel_q    <= ssel_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		drive_d   = drive_q;
		reached_d = reached_q;
		goal_d    = goal_q;
		tsel_d    = tsel_q;
		ssel_d    = ssel_q;
		cmd       = '0;
		tbl_wr    = 1'b0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_take) begin
					tsel_d = 1'b0;
					ssel_d = 1'b0;
					if (func) begin
						tbl_wr  = 1'b1;
						state_d = ST_OUT;
					end else if (reached_q) begin
						goal_d    = (5'(goal_q) + 5'd1 >= n) ? '0 : goal_q + 1'b1;
						reached_d = 1'b0;
						drive_d   = 1'b0;
						state_d   = ST_OUT;
					end else begin
						cmd.load_start = 1'b1;
						state_d        = ST_ITER;
					end
				end
			end
			ST_ITER: begin
				cmd.iter_en = 1'b1;
				if (sts.iter_done) state_d = ST_DIST;
			end
			ST_DIST: begin
				cmd.dist_en = 1'b1;
				state_d     = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide_en = 1'b1;
				if (!drive_q) begin
					if (sts.head_ok) drive_d = 1'b1;
					else tsel_d = 1'b1;
				end else begin
					if (sts.pos_ok || !sts.head_ok) drive_d = 1'b0;
					else ssel_d = 1'b1;
				end
				// Reached when no command went out and both tolerances hold.
				if (sts.pos_ok && sts.head_ok && !(drive_q && !sts.pos_ok)) begin
					if (!(drive_q && !sts.pos_ok && sts.head_ok)) begin
						reached_d = 1'b1;
						drive_d   = 1'b0;
					end
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign goal      = goal_q;
	assign phase     = reached_q ? PH_REACHED : (drive_q ? PH_DRIVE : PH_ROTATE);
	assign turn_sel  = tsel_q;
	assign speed_sel = ssel_q;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for the waypoint turn-then-drive controller top level.
// Drives pose and waypoint-load words and configuration writes, and predicts every result
// with a bit-exact model of the CORDIC go-to-goal controller. Depends on wptd_pkg and the top level.

// Scoreboard: keeps the predicted controller state and the queue of expected commands.
class nav_scoreboard;
	typedef struct {
		logic signed [15:0] turn;
		logic signed [15:0] speed;
		logic [1:0]         ph;
		logic [3:0]         goal;
	} nav_cmd_t;

	static const longint AtanTab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
		524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
		128, 64, 32, 16, 8, 4, 2};

	longint hgain, dgain, max_turn, max_speed, thresh, wp_count;
	longint wp_x[16], wp_y[16];
	int     goal_ptr;
	bit     driving, reached;
	nav_cmd_t pending[$];
	int     errors;

	function void reset_state();
		hgain = 5120; dgain = 2560; max_turn = 2048; max_speed = 128;
		thresh = 13; wp_count = 4;
		foreach (wp_x[i]) begin
			wp_x[i] = 0; wp_y[i] = 0;
		end
		wp_x[0] = 768;  wp_y[0] = 512;
		wp_x[1] = 1792; wp_y[1] = 512;
		wp_x[2] = 1792; wp_y[2] = 1792;
		wp_x[3] = 768;  wp_y[3] = 1792;
		goal_ptr = 0; driving = 0; reached = 0;
		pending.delete();
		errors = 0;
	endfunction

	function void write_reg(int idx, logic [15:0] val);
		case (idx)
			0: hgain = val;
			1: dgain = val;
			2: max_turn = val[14:0];
			3: max_speed = val[14:0];
			4: thresh = val[10:0];
			5: wp_count = val[4:0];
			default: ;
		endcase
	endfunction

	// Vectoring CORDIC on the goal offset; bearing in Q3.12, range in Q8.8.
	function void vector_to_goal(longint dx, longint dy, output longint bearing,
			output longint range);
		longint x, y, z, xs, ys;
		x = dx <<< 14; y = dy <<< 14; z = 0;
		if (dx == 0 && dy == 0) begin
			bearing = 0; range = 0;
			return;
		end
		if (x < 0) begin
			z = (y >= 0) ? 52707179 : -52707179;
			x = -x; y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += AtanTab[i];
			end else begin
				x -= ys; y += xs; z -= AtanTab[i];
			end
		end
		bearing = (z + 2048) >>> 12;
		range = (x * 10188014 + (longint'(1) << 37)) >>> 38;
	endfunction

	function void note_word(logic f, logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd, logic [3:0] slot, logic signed [15:0] lx,
			logic signed [15:0] ly);
		nav_cmd_t c;
		longint turn, speed, dx, dy, bearing, range, err, h, prod, lim, n, v;
		bit pos_ok, head_ok, issued;
		turn = 0; speed = 0; issued = 0;
		if (f) begin
			wp_x[slot] = lx; wp_y[slot] = ly;
		end else if (reached) begin
			n = (wp_count == 0) ? 1 : (wp_count > 16 ? 16 : wp_count);
			goal_ptr = (goal_ptr + 1 >= n) ? 0 : goal_ptr + 1;
			reached = 0; driving = 0;
		end else begin
			dx = wp_x[goal_ptr] - longint'(px);
			dy = wp_y[goal_ptr] - longint'(py);
			vector_to_goal(dx, dy, bearing, range);
			err = bearing - longint'(hd);
			pos_ok = (dx < 0 ? -dx : dx) <= thresh && (dy < 0 ? -dy : dy) <= thresh;
			head_ok = (err < 0 ? -err : err) <= thresh * 8;
			if (!driving) begin
				if (head_ok) driving = 1;
				else begin
					h = err;
					lim = max_turn << 8;
					if (h > 12868) h -= 25736;
					if (h < -12868) h += 25736;
					prod = hgain * h;
					if (prod > lim) turn = max_turn;
					else if (prod < -lim) turn = -max_turn;
					else turn = prod >>> 8;
					issued = 1;
				end
			end else begin
				if (pos_ok || !head_ok) driving = 0;
				else begin
					v = (dgain * range) >>> 8;
					if (v > max_speed) v = max_speed;
					speed = v;
					issued = 1;
				end
			end
			if (!issued && pos_ok && head_ok) begin
				reached = 1; driving = 0;
			end
		end
		c.turn = turn[15:0];
		c.speed = speed[15:0];
		c.ph = reached ? wptd_pkg::PH_REACHED : (driving ? wptd_pkg::PH_DRIVE
			: wptd_pkg::PH_ROTATE);
		c.goal = goal_ptr[3:0];
		pending.push_back(c);
	endfunction

	function void check_command(logic signed [15:0] tr, logic signed [15:0] fs,
			logic [1:0] ph, logic [3:0] gs);
		nav_cmd_t c;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word tr=%0d fs=%0d ph=%0d goal=%0d",
				$time, tr, fs, ph, gs);
			errors++;
			return;
		end
		c = pending.pop_front();
		if (tr !== c.turn) begin
			$display("%0t: turn_rate expected %0d actual %0d", $time, c.turn, tr);
			errors++;
		end
		if (fs !== c.speed) begin
			$display("%0t: forward_speed expected %0d actual %0d", $time, c.speed, fs);
			errors++;
		end
		if (ph !== c.ph) begin
			$display("%0t: phase expected %0d actual %0d", $time, c.ph, ph);
			errors++;
		end
		if (gs !== c.goal) begin
			$display("%0t: goal_slot expected %0d actual %0d", $time, c.goal, gs);
			errors++;
		end
	endfunction
endclass

module testbench;
	import wptd_pkg::*;

	localparam int CfgHeadingGain = 0;
	localparam int CfgDistGain    = 1;
	localparam int CfgMaxTurn     = 2;
	localparam int CfgMaxSpeed    = 3;
	localparam int CfgThreshold   = 4;
	localparam int CfgWpCount     = 5;
	localparam logic FuncStep = 1'b0;
	localparam logic FuncLoad = 1'b1;
	localparam int IdleLimit = 20000;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall;
	logic func = 0;
	logic signed [15:0] pose_x = 0, pose_y = 0, pose_heading = 0, load_x = 0, load_y = 0;
	logic [3:0] load_slot = 0;
	logic out_valid, out_stall = 0;
	logic signed [15:0] turn_rate, forward_speed;
	logic [1:0] phase;
	logic [3:0] goal_slot;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [15:0] cfg_data = 0;

	nav_scoreboard board;
	bit hold_output = 0;
	int idle_cycles = 0;

	waypoint_turn_then_drive_controller_top uut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic write_cfg(int idx, logic [15:0] val);
		cfg_valid <= 1; cfg_index <= idx[2:0]; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Lets everything drain, including the tail of a word still inside the block.
	task automatic wait_drained();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_word(logic f, logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd, logic [3:0] slot, logic signed [15:0] lx,
			logic signed [15:0] ly, bit pace);
		int g;
		g = pace ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1; func <= f; pose_x <= px; pose_y <= py; pose_heading <= hd;
		load_slot <= slot; load_x <= lx; load_y <= ly;
		do @(posedge clk); while (in_stall);
		board.note_word(f, px, py, hd, slot, lx, ly);
	endtask

	task automatic step_pose(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] hd);
		send_word(FuncStep, px, py, hd, 4'($urandom), 16'($urandom), 16'($urandom), 1'b1);
	endtask

	task automatic load_wp(logic [3:0] slot, logic signed [15:0] lx, logic signed [15:0] ly);
		send_word(FuncLoad, 16'($urandom), 16'($urandom), 16'($urandom), slot, lx, ly, 1'b1);
	endtask

	// Receiver: random stalls, plus a long forced hold-off when requested.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_command(turn_rate, forward_speed, phase, goal_slot);
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_output) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_output = 0;
			end
			g = gap_len();
			if ($urandom_range(0, 3) == 0) g = 0;
			out_stall <= (g > 0);
			repeat (g > 0 ? g : 1) @(posedge clk);
			out_stall <= 0;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Places the robot at random points near the current goal, mostly facing it, so the
	// controller passes through rotate, drive and reached.
	task automatic chase_goal(int steps, int noise);
		longint gx, gy, dxr, dyr, hd;
		real ang;
		for (int s = 0; s < steps; s++) begin
			gx = board.wp_x[board.goal_ptr]; gy = board.wp_y[board.goal_ptr];
			dxr = gx - 20 + $urandom_range(0, 40);
			dyr = gy - 20 + $urandom_range(0, 40);
			if ($urandom_range(0, 2) == 0) begin
				dxr = gx + $signed($urandom_range(0, 2 * noise)) - noise;
				dyr = gy + $signed($urandom_range(0, 2 * noise)) - noise;
			end
			ang = $atan2(real'(gy - dyr), real'(gx - dxr));
			hd = longint'(ang * 4096.0) + $signed($urandom_range(0, 200)) - 100;
			if ($urandom_range(0, 3) == 0) hd = $signed(16'($urandom));
			step_pose(dxr[15:0], dyr[15:0], hd[15:0]);
		end
	endtask

	initial begin
		board = new();
		board.reset_state();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every function, goal on pose, slot wrap.
		step_pose(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		step_pose(-16'sd32768, -16'sd32768, -16'sd32768);
		step_pose(16'sd768, 16'sd512, 16'sd0);
		step_pose(16'sd768, 16'sd512, 16'sd0);
		step_pose(16'sd768, 16'sd512, 16'sd0);
		step_pose(16'sd0, 16'sd512, 16'sd0);
		step_pose(16'sd1792, 16'sd400, 16'sd12000);
		step_pose(16'sd1792, 16'sd400, -16'sd12000);
		load_wp(4'd15, 16'sh7FFF, -16'sd32768);
		load_wp(4'd0, -16'sd32768, 16'sh7FFF);
		load_wp(4'd5, 16'sh5555, -16'sh5556);
		step_pose(16'sh7FFF, -16'sd32768, 16'sd0);
		step_pose(16'sh2AAA, 16'sh5555, 16'shAAAA);
		wait_drained();
		write_cfg(CfgWpCount, 16'd0);
		write_cfg(CfgThreshold, 16'd2047);
		step_pose(16'sd0, 16'sd0, 16'sd0);
		step_pose(16'sd0, 16'sd0, 16'sd0);
		step_pose(16'sd0, 16'sd0, 16'sd0);
		wait_drained();

		for (int phs = 0; phs < 6; phs++) begin
			case (phs)
				0: begin
					write_cfg(CfgHeadingGain, 16'hFFFF); write_cfg(CfgDistGain, 16'hFFFF);
					write_cfg(CfgMaxTurn, 16'h7FFF); write_cfg(CfgMaxSpeed, 16'h7FFF);
					write_cfg(CfgThreshold, 16'd40); write_cfg(CfgWpCount, 16'd16);
				end
				1: begin
					write_cfg(CfgHeadingGain, 16'd0); write_cfg(CfgDistGain, 16'd0);
					write_cfg(CfgMaxTurn, 16'd0); write_cfg(CfgMaxSpeed, 16'd0);
					write_cfg(CfgThreshold, 16'd0); write_cfg(CfgWpCount, 16'd31);
				end
				5: begin
					write_cfg(CfgHeadingGain, 16'd5120); write_cfg(CfgDistGain, 16'd2560);
					write_cfg(CfgMaxTurn, 16'd2048); write_cfg(CfgMaxSpeed, 16'd128);
					write_cfg(CfgThreshold, 16'd13); write_cfg(CfgWpCount, 16'd1);
				end
				default: begin
					write_cfg(CfgHeadingGain, 16'($urandom));
					write_cfg(CfgDistGain, 16'($urandom));
					write_cfg(CfgMaxTurn, 16'($urandom));
					write_cfg(CfgMaxSpeed, 16'($urandom));
					write_cfg(CfgThreshold, 16'($urandom_range(0, 60)));
					write_cfg(CfgWpCount, 16'($urandom_range(1, 17)));
				end
			endcase
			if (phs == 2) hold_output = 1;
			for (int k = 0; k < 300; k++) begin
				if ($urandom_range(0, 9) == 0) load_wp(4'($urandom),
					16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)));
				else if ($urandom_range(0, 9) == 0)
					step_pose(16'($urandom), 16'($urandom), 16'($urandom));
				else chase_goal(1, int'(board.thresh + 2));
			end
			// Sender pause until every result is back.
			wait_drained();
		end
		wait_drained();
		if (board.errors == 0 && board.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
